@@ sv/fivar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fivar_pkg
// Shared widths, defaults and the sequencer state type of the frame interval
// running variance block.
// ----------------------------------------------------------------------------
package fivar_pkg;

    // Field widths
    localparam int TIME_W     = 48;
    localparam int INTERVAL_W = 32;
    localparam int COUNT_W    = 32;
    localparam int MEAN_OUT_W = 40;
    localparam int M2_W       = 64;

    // Default fraction bits of the running mean
    localparam int MEAN_FRACTION_BITS_DEF = 8;

    // Iteration counter covers the longest pass (the 64-bit division)
    localparam int ITER_W = $clog2(M2_W + 1);

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV_MEAN,
        S_MEAN,
        S_D2,
        S_MUL,
        S_ACC,
        S_DIV_VAR,
        S_FINISH
    } state_t;

endpackage

@@ sv/fivar_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fivar_in_if
// Frame arrival channel: valid/ready handshake with the arrival timestamp.
// ----------------------------------------------------------------------------
interface fivar_in_if;
    logic                            valid;
    logic                            ready;
    logic [fivar_pkg::TIME_W-1:0]    arrival_time_us;

    modport source (output valid, output arrival_time_us, input ready);
    modport sink   (input valid, input arrival_time_us, output ready);
endinterface

@@ sv/fivar_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fivar_out_if
// Statistics result channel: valid/ready handshake with interval, count,
// running mean and sample variance.
// ----------------------------------------------------------------------------
interface fivar_out_if;
    logic                                valid;
    logic                                ready;
    logic [fivar_pkg::INTERVAL_W-1:0]    interval_us;
    logic [fivar_pkg::COUNT_W-1:0]       sample_count;
    logic [fivar_pkg::MEAN_OUT_W-1:0]    mean_interval;
    logic                                variance_valid;
    logic [fivar_pkg::M2_W-1:0]          variance;

    modport source (
        output valid, output interval_us, output sample_count,
        output mean_interval, output variance_valid, output variance,
        input  ready
    );
    modport sink (
        input  valid, input interval_us, input sample_count,
        input  mean_interval, input variance_valid, input variance,
        output ready
    );
endinterface

@@ sv/frame_interval_running_variance.sv @@
`timescale 1ns / 1ps
// With W = 32 + MEAN_FRACTION_BITS, a frame runs the mean division, a
// bit-serial multiply and, once two intervals exist, the variance division
// before its result is registered; the first frame after reset skips all
// three. One shared restoring divider (W then 64 steps, one bit per cycle)
// does both divisions. A new frame is taken only when idle. Reset clears the
// statistics and waits for a first frame again.
// ----------------------------------------------------------------------------
// frame_interval_running_variance
// Welford running mean and sample variance of frame arrival intervals, in
// fixed point, built around one serial divider and one serial multiplier.
// ----------------------------------------------------------------------------
module frame_interval_running_variance #(
    parameter int MEAN_FRACTION_BITS = fivar_pkg::MEAN_FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    fivar_in_if.sink     frame,
    fivar_out_if.source  stats
);

    localparam int MW    = fivar_pkg::INTERVAL_W + MEAN_FRACTION_BITS;
    localparam int ACC_W = 2 * MW;
    localparam int DW    = fivar_pkg::M2_W;
    localparam int CW    = fivar_pkg::COUNT_W;
    localparam int IW    = fivar_pkg::ITER_W;

    localparam logic [CW-1:0]   COUNT_MAX = '1;
    localparam logic [DW-1:0]   M2_MAX    = '1;
    localparam logic [63:0]     MEAN_SAT  = 64'((65'd1 << fivar_pkg::MEAN_OUT_W) - 65'd1);

    // Sequencer and statistics state
    fivar_pkg::state_t              state_reg, state_next;
    logic                           first_reg;
    logic [fivar_pkg::TIME_W-1:0]   prev_reg;
    logic [CW-1:0]                  count_reg;
    logic [MW-1:0]                  mean_reg;
    logic [DW-1:0]                  m2_reg;
    logic [IW-1:0]                  iter_reg;
    logic                           out_valid_reg;

    // Datapath (no reset)
    logic [fivar_pkg::INTERVAL_W-1:0] interval_reg;
    logic                           neg_reg;
    logic [MW-1:0]                  d1_reg;
    logic [DW-1:0]                  div_reg;
    logic [CW-1:0]                  rem_reg;
    logic [CW-1:0]                  divisor_reg;
    logic [ACC_W-1:0]               acc_reg;

    logic [fivar_pkg::INTERVAL_W-1:0] out_interval_reg;
    logic [CW-1:0]                  out_count_reg;
    logic [fivar_pkg::MEAN_OUT_W-1:0] out_mean_reg;
    logic                           out_vvalid_reg;
    logic [DW-1:0]                  out_var_reg;

    // Control strobes
    logic                           in_ready;
    logic                           accept;
    logic                           div_step;
    logic                           fin_load;
    logic                           last_iter;

    // Combinational datapath terms
    logic [fivar_pkg::TIME_W-1:0]   time_diff;
    logic [fivar_pkg::INTERVAL_W-1:0] interval_sat;
    logic [MW-1:0]                  xs;
    logic [MW-1:0]                  quot;
    logic [MW-1:0]                  d2;
    logic [CW:0]                    rem_sh;
    logic                           rem_ge;
    logic [MW:0]                    mul_sum;
    logic [DW-1:0]                  m2_step;
    logic [DW:0]                    m2_sum;
    logic [DW-1:0]                  m2_new;
    logic                           var_ok;

    assign accept    = frame.valid && in_ready;
    assign last_iter = (iter_reg == IW'(1));

    // Interval: 48-bit modular difference, saturated to 32 bits
    assign time_diff    = frame.arrival_time_us - prev_reg;
    assign interval_sat = (|time_diff[fivar_pkg::TIME_W-1:fivar_pkg::INTERVAL_W])
                          ? '1 : time_diff[fivar_pkg::INTERVAL_W-1:0];

    // Welford terms
    assign xs   = MW'(interval_reg) << MEAN_FRACTION_BITS;
    assign quot = div_reg[MW-1:0];
    assign d2   = neg_reg ? (mean_reg - xs) : (xs - mean_reg);

    // Restoring divider step, one quotient bit per cycle
    assign rem_sh = {rem_reg, div_reg[DW-1]};
    assign rem_ge = (rem_sh >= {1'b0, divisor_reg});

    // Shift-add multiplier step, multiplier in the low half of acc
    assign mul_sum = {1'b0, acc_reg[ACC_W-1:MW]} + {1'b0, (acc_reg[0] ? d1_reg : '0)};

    // Product scaled by 2^-(2F) is exactly 64 bits wide; saturating M2 add
    assign m2_step = acc_reg[ACC_W-1:2*MEAN_FRACTION_BITS];
    assign m2_sum  = {1'b0, m2_reg} + {1'b0, m2_step};
    assign m2_new  = m2_sum[DW] ? M2_MAX : m2_sum[DW-1:0];

    assign var_ok = (count_reg > CW'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fivar_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = first_reg ? fivar_pkg::S_FINISH : fivar_pkg::S_PREP;
            end
            fivar_pkg::S_PREP:     state_next = fivar_pkg::S_DIV_MEAN;
            fivar_pkg::S_DIV_MEAN:
            begin
                if (last_iter)
                    state_next = fivar_pkg::S_MEAN;
            end
            fivar_pkg::S_MEAN:     state_next = fivar_pkg::S_D2;
            fivar_pkg::S_D2:       state_next = fivar_pkg::S_MUL;
            fivar_pkg::S_MUL:
            begin
                if (last_iter)
                    state_next = fivar_pkg::S_ACC;
            end
            fivar_pkg::S_ACC:
                state_next = var_ok ? fivar_pkg::S_DIV_VAR : fivar_pkg::S_FINISH;
            fivar_pkg::S_DIV_VAR:
            begin
                if (last_iter)
                    state_next = fivar_pkg::S_FINISH;
            end
            fivar_pkg::S_FINISH:
            begin
                if (!out_valid_reg || stats.ready)
                    state_next = fivar_pkg::S_IDLE;
            end
            default:               state_next = fivar_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        div_step = 1'b0;
        fin_load = 1'b0;
        case (state_reg)
            fivar_pkg::S_IDLE:     in_ready = 1'b1;
            fivar_pkg::S_DIV_MEAN: div_step = 1'b1;
            fivar_pkg::S_DIV_VAR:  div_step = 1'b1;
            fivar_pkg::S_FINISH:   fin_load = !out_valid_reg || stats.ready;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fivar_pkg::S_IDLE;
            first_reg     <= 1'b1;
            prev_reg      <= '0;
            count_reg     <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                prev_reg  <= frame.arrival_time_us;
                first_reg <= 1'b0;
                if (!first_reg && count_reg != COUNT_MAX)
                    count_reg <= count_reg + CW'(1);
            end

            // Iteration counter for the serial passes
            case (state_reg)
                fivar_pkg::S_PREP: iter_reg <= IW'(MW);
                fivar_pkg::S_D2:   iter_reg <= IW'(MW);
                fivar_pkg::S_ACC:  iter_reg <= IW'(DW);
                default:
                begin
                    if (state_reg inside {fivar_pkg::S_DIV_MEAN, fivar_pkg::S_MUL,
                                          fivar_pkg::S_DIV_VAR})
                        iter_reg <= iter_reg - IW'(1);
                end
            endcase

            if (state_reg == fivar_pkg::S_MEAN)
                mean_reg <= neg_reg ? (mean_reg - quot) : (mean_reg + quot);

            if (state_reg == fivar_pkg::S_ACC)
                m2_reg <= m2_new;

            // Output register handshake
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (stats.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
            interval_reg <= first_reg ? '0 : interval_sat;

        case (state_reg)
            // Deviation from the mean, load divider left-aligned for W steps
            fivar_pkg::S_PREP:
            begin
                neg_reg     <= (xs < mean_reg);
                d1_reg      <= (xs < mean_reg) ? (mean_reg - xs) : (xs - mean_reg);
                div_reg     <= DW'((xs < mean_reg) ? (mean_reg - xs) : (xs - mean_reg))
                               << (DW - MW);
                rem_reg     <= '0;
                divisor_reg <= count_reg;
            end
            // Load multiplier with d2
            fivar_pkg::S_D2:
                acc_reg <= {{MW{1'b0}}, d2};
            fivar_pkg::S_MUL:
                acc_reg <= {mul_sum, acc_reg[MW-1:1]};
            // Load divider with the updated M2 over count - 1
            fivar_pkg::S_ACC:
            begin
                div_reg     <= m2_new;
                rem_reg     <= '0;
                divisor_reg <= count_reg - CW'(1);
            end
            default:
            begin
                if (div_step)
                begin
                    rem_reg <= rem_ge ? CW'(rem_sh - {1'b0, divisor_reg}) : rem_sh[CW-1:0];
                    div_reg <= {div_reg[DW-2:0], rem_ge};
                end
            end
        endcase

        // Result register
        if (fin_load)
        begin
            out_interval_reg <= interval_reg;
            out_count_reg    <= count_reg;
            out_mean_reg     <= (64'(mean_reg) > MEAN_SAT)
                                ? fivar_pkg::MEAN_OUT_W'(MEAN_SAT)
                                : fivar_pkg::MEAN_OUT_W'(64'(mean_reg));
            out_vvalid_reg   <= var_ok;
            out_var_reg      <= var_ok ? div_reg : '0;
        end
    end

    // Ports
    assign frame.ready          = in_ready;
    assign stats.valid          = out_valid_reg;
    assign stats.interval_us    = out_interval_reg;
    assign stats.sample_count   = out_count_reg;
    assign stats.mean_interval  = out_mean_reg;
    assign stats.variance_valid = out_vvalid_reg;
    assign stats.variance       = out_var_reg;

endmodule
